// ===== src/alsu_pkg.sv =====
// Shared types and constants of the ARM load/store unit.
package alsu_pkg;

  localparam int NUM_REGS      = 16;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int PENDING_DEPTH = 16;
  localparam int IQ_DEPTH      = 2;

  localparam logic [1:0]  HOP_UNSIGNED = 2'b01;
  localparam logic [31:0] WORD_BYTES   = 32'd4;
  localparam logic [31:0] HALF_MASK    = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    OP_WORD  = 3'd0,
    OP_BLOCK = 3'd1,
    OP_HALF  = 3'd2,
    OP_RESP  = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CMD_SINGLE,
    CMD_BLOCK,
    CMD_RESP,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BUS_RD = 2'd0,
    KIND_BUS_WR = 2'd1,
    KIND_REGVAL = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 load;
    logic                 pre;
    logic                 up;
    logic                 half;
    logic                 xfer;
    logic                 wb_base;
    logic                 reg_off;
    logic [REG_IDX_W-1:0] base_reg;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] off_reg;
    logic [11:0]          imm;
    logic [NUM_REGS-1:0]  reg_list;
    logic [31:0]          value;
  } item_t;

endpackage

// ===== src/alsu_front.sv =====
// Front end: accepts requests and classifies them into queued commands.
module alsu_front (
  input  logic                         start_i,
  input  logic [2:0]                   operation_i,
  input  logic                         load_i,
  input  logic                         pre_index_i,
  input  logic                         up_i,
  input  logic                         write_back_i,
  input  logic                         imm_offset_sel_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] base_reg_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] dest_reg_i,
  input  logic [11:0]                  offset_i,
  input  logic [alsu_pkg::NUM_REGS-1:0] reg_list_i,
  input  logic [1:0]                   half_opcode_i,
  input  logic [31:0]                  value_i,
  input  logic                         full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output alsu_pkg::item_t              item_o
);
  import alsu_pkg::*;

  logic known;

  assign busy_o = full_i;

  always_comb begin
    known           = 1'b1;
    item_o          = '0;
    item_o.load     = load_i;
    item_o.pre      = pre_index_i;
    item_o.up       = up_i;
    item_o.base_reg = base_reg_i;
    item_o.dest_reg = dest_reg_i;
    item_o.off_reg  = offset_i[REG_IDX_W-1:0];
    item_o.imm      = offset_i;
    item_o.reg_list = reg_list_i;
    item_o.value    = value_i;
    item_o.cmd      = CMD_SINGLE;
    case (operation_i)
      OP_WORD: begin
        item_o.xfer    = 1'b1;
        item_o.wb_base = !pre_index_i || write_back_i;
      end
      OP_HALF: begin
        // Only the unsigned halfword kind touches the bus; indexing still applies.
        item_o.half    = 1'b1;
        item_o.xfer    = (half_opcode_i == HOP_UNSIGNED);
        item_o.reg_off = !imm_offset_sel_i;
        item_o.wb_base = !pre_index_i || write_back_i;
      end
      OP_BLOCK: begin
        item_o.cmd     = CMD_BLOCK;
        item_o.wb_base = write_back_i;
      end
      OP_RESP:  item_o.cmd = CMD_RESP;
      OP_WRITE: item_o.cmd = CMD_WRITE;
      OP_READ:  item_o.cmd = CMD_READ;
      default:  known = 1'b0;
    endcase
  end

  // Unused operation codes change nothing, so they are dropped here.
  assign push_o = start_i && !full_i && known;

endmodule

// ===== src/alsu_fifo.sv =====
// Short command queue between the front end and the execution back end.
module alsu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  alsu_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output alsu_pkg::item_t item_o
);
  import alsu_pkg::*;

  localparam int PTR_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(IQ_DEPTH + 1);

  item_t            mem_q [IQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(IQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/alsu_back.sv =====
// Back end: register file, pending load queue and the transfer sequencer.
module alsu_back #(
  parameter int PendingDepth = alsu_pkg::PENDING_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  alsu_pkg::item_t item_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output logic [1:0]      out_kind_o,
  output logic [31:0]     address_o,
  output logic [31:0]     data_o,
  output logic            halfword_o,
  output logic            last_o
);
  import alsu_pkg::*;

  localparam int PIDX_W = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int PCNT_W = $clog2(PendingDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SADDR,
    S_SEMIT,
    S_BADDR,
    S_BEMIT,
    S_RDOUT
  } state_e;

  function automatic logic [REG_IDX_W-1:0] lowest_bit(input logic [NUM_REGS-1:0] m);
    logic [REG_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (m[i]) idx = REG_IDX_W'(i);
    end
    return idx;
  endfunction

  // Register file: two registered read ports, one write port, valid bits for reset.
  logic [31:0]          regs_q [NUM_REGS];
  logic [NUM_REGS-1:0]  reg_valid_q;
  logic [31:0]          rdata_a_q, rdata_b_q;
  logic [REG_IDX_W-1:0] rd_a_addr, rd_b_addr;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_addr;
  logic [31:0]          wr_data;

  // Pending load queue.
  logic [REG_IDX_W-1:0] pend_reg_q    [PendingDepth];
  logic                 pend_half_q   [PendingDepth];
  logic                 pend_cancel_q [PendingDepth];
  logic [PIDX_W-1:0]    head_q, tail_q;
  logic [PCNT_W-1:0]    pcnt_q;
  logic                 enq_en, pend_pop, cancel_en;
  logic [REG_IDX_W-1:0] enq_reg;
  logic                 enq_half;
  logic                 pend_full;

  // Sequencer.
  state_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [31:0]          addr_q, addr_d;
  logic [31:0]          moved_q, moved_d;
  logic [REG_IDX_W-1:0] cur_q, cur_d;
  logic [NUM_REGS-1:0]  rem_q, rem_d;
  logic                 res_valid_d;
  logic [1:0]           res_kind_d;
  logic [31:0]          res_addr_d, res_data_d;
  logic                 res_half_d, res_last_d;
  logic                 res_valid_q;
  logic [1:0]           res_kind_q;
  logic [31:0]          res_addr_q, res_data_q;
  logic                 res_half_q, res_last_q;

  logic [31:0]          offset_val, base_val, size_val, moved_val;
  logic [4:0]           sel_cnt;
  logic [NUM_REGS-1:0]  first_mask;

  assign pend_full = (pcnt_q == PCNT_W'(PendingDepth));

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    addr_d      = addr_q;
    moved_d     = moved_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    pop_o       = 1'b0;
    rd_a_addr   = item_q.dest_reg;
    rd_b_addr   = item_q.off_reg;
    wr_en       = 1'b0;
    wr_addr     = item_q.base_reg;
    wr_data     = moved_q;
    cancel_en   = 1'b0;
    enq_en      = 1'b0;
    enq_reg     = item_q.dest_reg;
    enq_half    = item_q.half;
    pend_pop    = 1'b0;
    res_valid_d = 1'b0;
    res_kind_d  = KIND_BUS_RD;
    res_addr_d  = addr_q;
    res_data_d  = '0;
    res_half_d  = 1'b0;
    res_last_d  = 1'b0;

    offset_val  = item_q.reg_off ? rdata_b_q : {20'b0, item_q.imm};
    base_val    = rdata_a_q;
    moved_val   = item_q.up ? base_val + offset_val : base_val - offset_val;
    sel_cnt     = 5'($countones(item_q.reg_list));
    size_val    = {25'b0, sel_cnt, 2'b00};
    first_mask  = '0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          item_d    = item_i;
          rd_a_addr = item_i.base_reg;
          rd_b_addr = item_i.off_reg;
          case (item_i.cmd)
            CMD_SINGLE: state_d = S_SADDR;
            CMD_BLOCK: begin
              // An empty register list leaves everything untouched.
              if (item_i.reg_list != '0) state_d = S_BADDR;
            end
            CMD_RESP: begin
              if (pcnt_q != '0) begin
                pend_pop = 1'b1;
                wr_en    = !pend_cancel_q[head_q];
                wr_addr  = pend_reg_q[head_q];
                wr_data  = pend_half_q[head_q] ? (item_i.value & HALF_MASK) : item_i.value;
              end
            end
            CMD_WRITE: begin
              wr_en   = 1'b1;
              wr_addr = item_i.dest_reg;
              wr_data = item_i.value;
            end
            CMD_READ: begin
              rd_a_addr = item_i.dest_reg;
              state_d   = S_RDOUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SADDR: begin
        moved_d   = moved_val;
        addr_d    = item_q.pre ? moved_val : base_val;
        rd_a_addr = item_q.dest_reg;
        state_d   = S_SEMIT;
      end
      S_SEMIT: begin
        if (item_q.xfer) begin
          res_valid_d = 1'b1;
          res_kind_d  = item_q.load ? KIND_BUS_RD : KIND_BUS_WR;
          res_half_d  = item_q.half;
          res_last_d  = 1'b1;
          if (!item_q.load) begin
            res_data_d = item_q.half ? (rdata_a_q & HALF_MASK) : rdata_a_q;
          end
          enq_en = item_q.load;
        end
        wr_en     = item_q.wb_base;
        cancel_en = item_q.wb_base;
        state_d   = S_IDLE;
      end
      S_BADDR: begin
        if (item_q.up) begin
          addr_d  = item_q.pre ? base_val + WORD_BYTES : base_val;
          moved_d = base_val + size_val;
        end else begin
          addr_d  = item_q.pre ? base_val - size_val : base_val - size_val + WORD_BYTES;
          moved_d = base_val - size_val;
        end
        cur_d      = lowest_bit(item_q.reg_list);
        first_mask = NUM_REGS'(1) << cur_d;
        rem_d      = item_q.reg_list & ~first_mask;
        rd_a_addr  = cur_d;
        state_d    = S_BEMIT;
      end
      S_BEMIT: begin
        res_valid_d = 1'b1;
        res_kind_d  = item_q.load ? KIND_BUS_RD : KIND_BUS_WR;
        res_data_d  = item_q.load ? '0 : rdata_a_q;
        res_last_d  = (rem_q == '0);
        enq_en      = item_q.load;
        enq_reg     = cur_q;
        enq_half    = 1'b0;
        addr_d      = addr_q + WORD_BYTES;
        if (rem_q != '0) begin
          cur_d      = lowest_bit(rem_q);
          first_mask = NUM_REGS'(1) << cur_d;
          rem_d      = rem_q & ~first_mask;
          rd_a_addr  = cur_d;
        end else begin
          // The base update also cancels loads queued by this same request.
          wr_en     = item_q.wb_base;
          cancel_en = item_q.wb_base;
          state_d   = S_IDLE;
        end
      end
      S_RDOUT: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_REGVAL;
        res_addr_d  = '0;
        res_data_d  = rdata_a_q;
        res_last_d  = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      item_q      <= '0;
      addr_q      <= '0;
      moved_q     <= '0;
      cur_q       <= '0;
      rem_q       <= '0;
      res_kind_q  <= '0;
      res_addr_q  <= '0;
      res_data_q  <= '0;
      res_half_q  <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      item_q      <= item_d;
      addr_q      <= addr_d;
      moved_q     <= moved_d;
      cur_q       <= cur_d;
      rem_q       <= rem_d;
      res_kind_q  <= res_kind_d;
      res_addr_q  <= res_addr_d;
      res_data_q  <= res_data_d;
      res_half_q  <= res_half_d;
      res_last_q  <= res_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_valid_q <= '0;
    end else if (wr_en) begin
      reg_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      regs_q[wr_addr] <= wr_data;
    end
    rdata_a_q <= reg_valid_q[rd_a_addr] ? regs_q[rd_a_addr] : '0;
    rdata_b_q <= reg_valid_q[rd_b_addr] ? regs_q[rd_b_addr] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      pcnt_q <= '0;
    end else begin
      if (enq_en && !pend_full) begin
        tail_q <= (tail_q == PIDX_W'(PendingDepth - 1)) ? '0 : tail_q + 1'b1;
        pcnt_q <= pcnt_q + 1'b1;
      end else if (pend_pop) begin
        head_q <= (head_q == PIDX_W'(PendingDepth - 1)) ? '0 : head_q + 1'b1;
        pcnt_q <= pcnt_q - 1'b1;
      end
    end
  end

  // Entries outside the queue may be marked too; they are rewritten on enqueue.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PendingDepth; i++) begin
      if (enq_en && !pend_full && (tail_q == PIDX_W'(i))) begin
        pend_cancel_q[i] <= cancel_en && (enq_reg == wr_addr);
      end else if (cancel_en && (pend_reg_q[i] == wr_addr)) begin
        pend_cancel_q[i] <= 1'b1;
      end
    end
    if (enq_en && !pend_full) begin
      pend_reg_q[tail_q]  <= enq_reg;
      pend_half_q[tail_q] <= enq_half;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_kind_o     = res_kind_q;
  assign address_o      = res_addr_q;
  assign data_o         = res_data_q;
  assign halfword_o     = res_half_q;
  assign last_o         = res_last_q;

endmodule

// ===== src/arm_load_store_unit.sv =====
// Top level of the ARM load/store unit: front end, command queue and back end.
//
// A request is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry command queue is full. Results appear for one cycle with
// result_valid_o and cannot be held off. In the back end a response or a
// register write is done in the idle state as it is taken, a register read
// passes through a read-out state, a word or halfword transfer through an
// address and an emit state, and a block transfer through an address state
// and one emit state per selected register, each emitting one bus request.
// The two register read ports are registered; one queued command runs at a time.
module arm_load_store_unit #(
  parameter int PendingDepth = alsu_pkg::PENDING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    operation_i,
  input  logic                          load_i,
  input  logic                          pre_index_i,
  input  logic                          up_i,
  input  logic                          write_back_i,
  input  logic                          imm_offset_sel_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] base_reg_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] dest_reg_i,
  input  logic [11:0]                   offset_i,
  input  logic [alsu_pkg::NUM_REGS-1:0] reg_list_i,
  input  logic [1:0]                    half_opcode_i,
  input  logic [31:0]                   value_i,
  output logic                          result_valid_o,
  output logic [1:0]                    out_kind_o,
  output logic [31:0]                   address_o,
  output logic [31:0]                   data_o,
  output logic                          halfword_o,
  output logic                          last_o
);
  import alsu_pkg::*;

  item_t push_item, head_item;
  logic  push, pop, full, empty;

  alsu_front u_front (
    .start_i          (start_i),
    .operation_i      (operation_i),
    .load_i           (load_i),
    .pre_index_i      (pre_index_i),
    .up_i             (up_i),
    .write_back_i     (write_back_i),
    .imm_offset_sel_i (imm_offset_sel_i),
    .base_reg_i       (base_reg_i),
    .dest_reg_i       (dest_reg_i),
    .offset_i         (offset_i),
    .reg_list_i       (reg_list_i),
    .half_opcode_i    (half_opcode_i),
    .value_i          (value_i),
    .full_i           (full),
    .busy_o           (busy_o),
    .push_o           (push),
    .item_o           (push_item)
  );

  alsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (head_item)
  );

  alsu_back #(
    .PendingDepth (PendingDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .out_kind_o     (out_kind_o),
    .address_o      (address_o),
    .data_o         (data_o),
    .halfword_o     (halfword_o),
    .last_o         (last_o)
  );

endmodule

// ===== src/alsu_checker.sv =====
// Port-level checks of the load/store unit, bound to the top level.
module alsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  out_kind_o,
  input logic [31:0] address_o,
  input logic [31:0] data_o,
  input logic        halfword_o,
  input logic        last_o
);
  import alsu_pkg::*;

  // A block transfer streams its bus requests in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("block transfer stream broken");

  // Requests within one block transfer walk upward one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> address_o == $past(address_o) + 32'd4)
    else $error("block transfer address step wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> out_kind_o == $past(out_kind_o) && !halfword_o)
    else $error("block transfer changed request kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && out_kind_o == KIND_REGVAL |-> address_o == '0 && !halfword_o && last_o)
    else $error("malformed register value result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && halfword_o |-> last_o && data_o[31:16] == '0)
    else $error("malformed halfword request");

endmodule

bind arm_load_store_unit alsu_checker u_alsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .out_kind_o     (out_kind_o),
  .address_o      (address_o),
  .data_o         (data_o),
  .halfword_o     (halfword_o),
  .last_o         (last_o)
);

// ===== bench/lsu_result_checker.sv =====
// Checker for the load/store unit: predicts every result from the accepted requests and compares.
module lsu_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [2:0]                     operation_i,
  input  logic                           load_i,
  input  logic                           pre_index_i,
  input  logic                           up_i,
  input  logic                           write_back_i,
  input  logic                           imm_offset_sel_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] base_reg_i,
  input  logic [alsu_pkg::REG_IDX_W-1:0] dest_reg_i,
  input  logic [11:0]                    offset_i,
  input  logic [alsu_pkg::NUM_REGS-1:0]  reg_list_i,
  input  logic [1:0]                     half_opcode_i,
  input  logic [31:0]                    value_i,
  input  logic                           result_valid_i,
  input  logic [1:0]                     out_kind_i,
  input  logic [31:0]                    address_i,
  input  logic [31:0]                    data_i,
  input  logic                           halfword_i,
  input  logic                           last_i,
  output int                             mismatch_cnt_o,
  output int                             results_owed_o
);
  import alsu_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [31:0] data;
    logic        half;
    logic        last;
  } bus_result_t;

  typedef struct packed {
    logic                 cancel;
    logic                 half;
    logic [REG_IDX_W-1:0] dest;
  } load_slot_t;

  logic [31:0]  gpr [NUM_REGS];
  load_slot_t   load_fifo [PENDING_DEPTH];
  int unsigned  load_head;
  int unsigned  load_count;
  int           mismatches;
  bus_result_t  expected_results [$];

  function automatic void expect_result(kind_e kind, logic [31:0] addr, logic [31:0] data,
                                        logic half, logic last);
    bus_result_t r;
    r.kind    = kind;
    r.address = addr;
    r.data    = data;
    r.half    = half;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  // A full queue still issues the bus read; the destination is simply lost.
  function automatic void track_load(logic [REG_IDX_W-1:0] dest, logic half);
    int unsigned slot;
    if (load_count < PENDING_DEPTH) begin
      slot = (load_head + load_count) % PENDING_DEPTH;
      load_fifo[slot] = '{cancel: 1'b0, half: half, dest: dest};
      load_count++;
    end
  endfunction

  // Writing the base kills any outstanding load aimed at the same register.
  function automatic void write_base(logic [REG_IDX_W-1:0] rn, logic [31:0] addr);
    int unsigned slot;
    gpr[rn] = addr;
    for (int unsigned i = 0; i < load_count; i++) begin
      slot = (load_head + i) % PENDING_DEPTH;
      if (load_fifo[slot].dest == rn) load_fifo[slot].cancel = 1'b1;
    end
  endfunction

  function automatic void predict_single(logic half);
    logic [31:0] base;
    logic [31:0] off;
    logic [31:0] moved;
    logic [31:0] addr;
    logic [31:0] store_data;
    base  = gpr[base_reg_i];
    off   = (half && !imm_offset_sel_i) ? gpr[offset_i[REG_IDX_W-1:0]] : {20'b0, offset_i};
    moved = up_i ? base + off : base - off;
    addr  = pre_index_i ? moved : base;
    if (!half || half_opcode_i == HOP_UNSIGNED) begin
      if (load_i) begin
        expect_result(KIND_BUS_RD, addr, 32'b0, half, 1'b1);
        track_load(dest_reg_i, half);
      end else begin
        store_data = half ? (gpr[dest_reg_i] & HALF_MASK) : gpr[dest_reg_i];
        expect_result(KIND_BUS_WR, addr, store_data, half, 1'b1);
      end
    end
    if (!pre_index_i || write_back_i) write_base(base_reg_i, moved);
  endfunction

  function automatic void predict_block();
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] addr;
    int          n_regs;
    int          done;
    base   = gpr[base_reg_i];
    n_regs = $countones(reg_list_i);
    if (n_regs != 0) begin
      span = WORD_BYTES * n_regs;
      if (up_i) addr = pre_index_i ? base + WORD_BYTES : base;
      else      addr = pre_index_i ? base - span : base - (span - WORD_BYTES);
      done = 0;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (reg_list_i[i]) begin
          done++;
          if (load_i) begin
            expect_result(KIND_BUS_RD, addr, 32'b0, 1'b0, done == n_regs);
            track_load(i[REG_IDX_W-1:0], 1'b0);
          end else begin
            expect_result(KIND_BUS_WR, addr, gpr[i], 1'b0, done == n_regs);
          end
          addr += WORD_BYTES;
        end
      end
      if (write_back_i) write_base(base_reg_i, up_i ? base + span : base - span);
    end
  endfunction

  function automatic void retire_load();
    load_slot_t e;
    if (load_count > 0) begin
      e         = load_fifo[load_head];
      load_head = (load_head + 1) % PENDING_DEPTH;
      load_count--;
      if (!e.cancel) gpr[e.dest] = e.half ? (value_i & HALF_MASK) : value_i;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t got;
    bus_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      load_head  = 0;
      load_count = 0;
      expected_results.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      results_owed_o <= 0;
    end else begin
      // Results of the request taken at this edge cannot appear before the next one.
      if (result_valid_i) begin
        got.kind    = kind_e'(out_kind_i);
        got.address = address_i;
        got.data    = data_i;
        got.half    = halfword_i;
        got.last    = last_i;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result kind %0d addr %h data %h half %b last %b",
                   $time, out_kind_i, address_i, data_i, halfword_i, last_i);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected kind %0d addr %h data %h half %b last %b", $time,
                     want.kind, want.address, want.data, want.half, want.last);
            $display("%0t:   actual kind %0d addr %h data %h half %b last %b", $time,
                     out_kind_i, address_i, data_i, halfword_i, last_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        case (operation_i)
          OP_WORD:  predict_single(1'b0);
          OP_BLOCK: predict_block();
          OP_HALF:  predict_single(1'b1);
          OP_RESP:  retire_load();
          OP_WRITE: gpr[dest_reg_i] = value_i;
          OP_READ:  expect_result(KIND_REGVAL, 32'b0, gpr[dest_reg_i], 1'b0, 1'b1);
          default: ;
        endcase
      end
      mismatch_cnt_o <= mismatches;
      results_owed_o <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb_arm_load_store_unit.sv =====
// Testbench top for the load/store unit: reset, clock, request stimulus and the verdict.
module tb_arm_load_store_unit;
  import alsu_pkg::*;

  localparam logic [2:0] OP_SPARE_6  = 3'd6;
  localparam logic [2:0] OP_SPARE_7  = 3'd7;
  localparam int         RANDOM_REQS = 456;
  localparam int         SETTLE_CYC  = 64;
  localparam int         CYCLE_LIMIT = 200000;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [2:0]           operation_i = '0;
  logic                 load_i = 1'b0;
  logic                 pre_index_i = 1'b0;
  logic                 up_i = 1'b0;
  logic                 write_back_i = 1'b0;
  logic                 imm_offset_sel_i = 1'b0;
  logic [REG_IDX_W-1:0] base_reg_i = '0;
  logic [REG_IDX_W-1:0] dest_reg_i = '0;
  logic [11:0]          offset_i = '0;
  logic [NUM_REGS-1:0]  reg_list_i = '0;
  logic [1:0]           half_opcode_i = '0;
  logic [31:0]          value_i = '0;
  logic                 result_valid_o;
  logic [1:0]           out_kind_o;
  logic [31:0]          address_o;
  logic [31:0]          data_o;
  logic                 halfword_o;
  logic                 last_o;

  int mismatch_cnt;
  int results_owed;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  arm_load_store_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .load_i, .pre_index_i, .up_i,
    .write_back_i, .imm_offset_sel_i, .base_reg_i, .dest_reg_i, .offset_i, .reg_list_i,
    .half_opcode_i, .value_i, .result_valid_o, .out_kind_o, .address_o, .data_o,
    .halfword_o, .last_o
  );

  lsu_result_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .load_i, .pre_index_i, .up_i,
    .write_back_i, .imm_offset_sel_i, .base_reg_i, .dest_reg_i, .offset_i, .reg_list_i,
    .half_opcode_i, .value_i, .result_valid_i(result_valid_o), .out_kind_i(out_kind_o),
    .address_i(address_o), .data_i(data_o), .halfword_i(halfword_o), .last_i(last_o),
    .mismatch_cnt_o(mismatch_cnt), .results_owed_o(results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Holds a request until the unit takes it, then now and then leaves a gap.
  task automatic issue(input logic [2:0] op, input logic ld, input logic pre, input logic up,
                       input logic wb, input logic isel, input logic [REG_IDX_W-1:0] rn,
                       input logic [REG_IDX_W-1:0] rd, input logic [11:0] off,
                       input logic [NUM_REGS-1:0] list, input logic [1:0] hop,
                       input logic [31:0] val);
    start_i          <= 1'b1;
    operation_i      <= op;
    load_i           <= ld;
    pre_index_i      <= pre;
    up_i             <= up;
    write_back_i     <= wb;
    imm_offset_sel_i <= isel;
    base_reg_i       <= rn;
    dest_reg_i       <= rd;
    offset_i         <= off;
    reg_list_i       <= list;
    half_opcode_i    <= hop;
    value_i          <= val;
    do @(posedge clk_i); while (busy_o);
    if (gaps_on && $urandom_range(99) < 10) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Fields that an operation ignores are filled with noise.
  task automatic word_xfer(input logic ld, input logic pre, input logic up, input logic wb,
                           input logic [REG_IDX_W-1:0] rn, input logic [REG_IDX_W-1:0] rd,
                           input logic [11:0] off);
    issue(OP_WORD, ld, pre, up, wb, 1'($urandom), rn, rd, off, NUM_REGS'($urandom),
          2'($urandom), $urandom);
  endtask

  task automatic half_xfer(input logic ld, input logic pre, input logic up, input logic wb,
                           input logic isel, input logic [REG_IDX_W-1:0] rn,
                           input logic [REG_IDX_W-1:0] rd, input logic [11:0] off,
                           input logic [1:0] hop);
    issue(OP_HALF, ld, pre, up, wb, isel, rn, rd, off, NUM_REGS'($urandom), hop, $urandom);
  endtask

  task automatic block_xfer(input logic ld, input logic pre, input logic up, input logic wb,
                            input logic [REG_IDX_W-1:0] rn, input logic [NUM_REGS-1:0] list);
    issue(OP_BLOCK, ld, pre, up, wb, 1'($urandom), rn, REG_IDX_W'($urandom), 12'($urandom),
          list, 2'($urandom), $urandom);
  endtask

  task automatic respond(input logic [31:0] val);
    issue(OP_RESP, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
          REG_IDX_W'($urandom), REG_IDX_W'($urandom), 12'($urandom), NUM_REGS'($urandom),
          2'($urandom), val);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] rd, input logic [31:0] val);
    issue(OP_WRITE, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
          REG_IDX_W'($urandom), rd, 12'($urandom), NUM_REGS'($urandom), 2'($urandom), val);
  endtask

  task automatic reg_read(input logic [REG_IDX_W-1:0] rd);
    issue(OP_READ, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
          REG_IDX_W'($urandom), rd, 12'($urandom), NUM_REGS'($urandom), 2'($urandom),
          $urandom);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  function automatic logic [NUM_REGS-1:0] pick_list();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      2, 3:    return NUM_REGS'(1) << $urandom_range(NUM_REGS - 1);
      4, 5, 6: return NUM_REGS'($urandom & $urandom & $urandom);
      default: return NUM_REGS'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_offset();
    return ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(63));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFF0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    respond(32'h1111_2222);                          // nothing is pending yet
    reg_write(4'd1, 32'h0000_1000);
    reg_write(4'd2, 32'hFFFF_FFFC);
    reg_write(4'd3, 32'hA5A5_1234);
    reg_read(4'd3);
    word_xfer(1'b0, 1'b1, 1'b1, 1'b1, 4'd1, 4'd3, 12'hFFF);
    word_xfer(1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 4'd4, 12'd4);   // the new base wraps below zero
    word_xfer(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd5, 12'd8);   // the address wraps above the top
    respond(32'hDEAD_BEEF);
    respond(32'h1234_5678);
    half_xfer(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd1, 4'd6, 12'h003, HOP_UNSIGNED);
    respond(32'hCAFE_F00D);
    half_xfer(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 4'd1, 4'd3, 12'hFFF, HOP_UNSIGNED);
    half_xfer(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 4'd2, 4'd7, 12'h010, 2'd0);
    half_xfer(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd7, 12'h00F, 2'd3);
    block_xfer(1'b0, 1'b0, 1'b1, 1'b1, 4'd1, 16'hFFFF);
    block_xfer(1'b0, 1'b1, 1'b0, 1'b0, 4'd2, 16'h8001);
    block_xfer(1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 16'h0F0F);
    block_xfer(1'b1, 1'b1, 1'b1, 1'b1, 4'd1, 16'h0000);
    // The base is also in the list, so its own load gets cancelled.
    block_xfer(1'b1, 1'b1, 1'b1, 1'b1, 4'd4, 16'h00F0);
    block_xfer(1'b1, 1'b0, 1'b1, 1'b0, 4'd9, 16'hFFFF);
    word_xfer(1'b1, 1'b0, 1'b1, 1'b1, 4'd6, 4'd6, 12'h004); // the load queue is full here
    issue(OP_SPARE_6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 4'd15, 12'hFFF, 16'hFFFF, 2'd3,
          32'hFFFF_FFFF);
    issue(OP_SPARE_7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0, 12'h000, 16'h0000, 2'd0,
          32'h0000_0000);
    reg_read(4'd15);
    wait_drained();

    // Random part: mostly transfers paired with enough responses to keep loads flowing.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      gaps_on = !(n >= 120 && n < 260);
      if (n == 200) wait_drained();
      sel = $urandom_range(99);
      if (sel < 18)
        word_xfer(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  REG_IDX_W'($urandom), REG_IDX_W'($urandom), pick_offset());
      else if (sel < 32)
        block_xfer(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   REG_IDX_W'($urandom), pick_list());
      else if (sel < 50)
        half_xfer(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  REG_IDX_W'($urandom), REG_IDX_W'($urandom), pick_offset(),
                  ($urandom_range(9) < 7) ? HOP_UNSIGNED : 2'($urandom));
      else if (sel < 72)
        respond($urandom);
      else if (sel < 85)
        reg_write(REG_IDX_W'($urandom), pick_value());
      else if (sel < 97)
        reg_read(REG_IDX_W'($urandom));
      else
        issue($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7, 1'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom), REG_IDX_W'($urandom),
              REG_IDX_W'($urandom), 12'($urandom), NUM_REGS'($urandom), 2'($urandom),
              $urandom);
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
